[hw/rtl/logi_pkg.sv]
// Shared types, constants and helper functions of the occupancy grid block.
`default_nettype none
package logi_pkg;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int MAX_MARGIN = 7;

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_AW = $clog2(GRID_COLS);
    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int M_W = $clog2(MAX_MARGIN + 1) + 1;
    localparam int D_W = M_W + 1;
    localparam int SQ_W = 2 * D_W + 1;
    localparam int CENTRE_ADDR = (GRID_ROWS / 2) * GRID_COLS + GRID_COLS / 2;

    localparam int TURN = 23040;
    localparam int QUARTER = 5760;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_GAIN = 652032874;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd2;

    localparam logic [2:0] CELL_FREE = 3'd0;
    localparam logic [2:0] CELL_OBST = 3'd1;
    localparam logic [2:0] CELL_LOC = 3'd2;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_ANG1, ST_ANG2, ST_ANG3, ST_CORDIC,
        ST_ROUND, ST_MUL, ST_DIVINIT, ST_DIV, ST_FIX, ST_BOUND, ST_RAWWR,
        ST_DISC, ST_RD, ST_RD2, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic clr;
        logic ang1;
        logic ang2;
        logic ang3;
        logic cordic;
        logic round;
        logic mul;
        logic divinit;
        logic div;
        logic fix;
        logic bound;
        logic rawwr;
        logic disc;
        logic rd;
        logic rd2;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req;
        logic skip;
        logic cordic_last;
        logic div_last;
        logic in_map;
        logic disc_last;
    } t_status;

    // Arctangent of 2^-i in units of 2^-22 degree.
    function automatic logic signed [31:0] atan_val(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd188743680;
            5'd1: v = 32'sd111421900;
            5'd2: v = 32'sd58872272;
            5'd3: v = 32'sd29884485;
            5'd4: v = 32'sd15000234;
            5'd5: v = 32'sd7507429;
            5'd6: v = 32'sd3754631;
            5'd7: v = 32'sd1877430;
            5'd8: v = 32'sd938729;
            5'd9: v = 32'sd469366;
            5'd10: v = 32'sd234683;
            5'd11: v = 32'sd117342;
            5'd12: v = 32'sd58671;
            5'd13: v = 32'sd29335;
            5'd14: v = 32'sd14668;
            5'd15: v = 32'sd7334;
            5'd16: v = 32'sd3667;
            5'd17: v = 32'sd1833;
            5'd18: v = 32'sd917;
            5'd19: v = 32'sd458;
            5'd20: v = 32'sd229;
            5'd21: v = 32'sd115;
            5'd22: v = 32'sd57;
            5'd23: v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic cell_in_map(input logic signed [17:0] x,
                                         input logic signed [17:0] y);
        return (x >= -18'sd1 * 18'(GRID_COLS / 2)) &&
               (x <= 18'(GRID_COLS - 1 - GRID_COLS / 2)) &&
               (y >= -18'sd1 * 18'(GRID_ROWS / 2)) &&
               (y <= 18'(GRID_ROWS - 1 - GRID_ROWS / 2));
    endfunction

    // Memory address of an in-map cell given as an offset from the centre.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [17:0] x,
                                                   input logic signed [17:0] y);
        logic [17:0] cx;
        logic [17:0] cy;
        cx = x + 18'(GRID_COLS / 2);
        cy = y + 18'(GRID_ROWS / 2);
        return ADDR_W'(32'(cy[ROW_AW-1:0]) * GRID_COLS + 32'(cx[COL_AW-1:0]));
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lidar_occupancy_grid_inflate.sv]
// Top level of the lidar occupancy grid with obstacle inflation.
//
// Usage: a transaction is offered by raising i_start with its fields; it is
// accepted at a rising edge where i_start is high and o_busy is low. A lidar
// sample (i_req_type low) is turned into a tile hit; an in-map hit marks the
// raw map cell and a disc of radius margin_tiles in the safe map as obstacle.
// A read (i_req_type high) returns both map codes of one cell.
// Each accepted transaction gives exactly one result, shown for a single cycle
// with o_valid high. The receiver cannot stall; it must take the result then.
// Path: a read passes the read states; a skipped sample goes straight
// to the result; an off-map sample runs the angle steps, the 24-step
// CORDIC, the multiply, the 16-step divider and the bounds check; an in-map
// sample also writes the raw cell and walks the square of side 2m+1 round
// the hit (m is the clamped margin) one cell per cycle, writing the cells in
// the disc and on the map through the single safe map write port. The next
// transaction can be taken in the cycle after o_valid. After reset both maps
// are cleared one cell per cycle while o_busy stays high; configuration writes
// are taken at any time and should only be made while the block is idle.
`default_nettype none
module lidar_occupancy_grid_inflate (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire logic                               i_req_type,
    input  wire logic [15:0]                        i_range_mm,
    input  wire logic [14:0]                        i_bearing,
    input  wire logic [7:0]                         i_quality,
    input  wire logic                               i_end_of_scan,
    input  wire logic signed [5:0]                  i_read_x,
    input  wire logic signed [5:0]                  i_read_y,
    input  wire logic                               i_cfg_we,
    input  wire logic [logi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [logi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                    o_valid,
    output logic signed [16:0]                      o_hit_x,
    output logic signed [16:0]                      o_hit_y,
    output logic                                    o_hit_in_map,
    output logic                                    o_sample_skipped,
    output logic [2:0]                              o_raw_cell,
    output logic [2:0]                              o_safe_cell,
    output logic                                    o_read_ok,
    output logic                                    o_scan_done
);

    // Configuration registers; an index beyond the list is ignored.
    logic [14:0] r_heading_offset;
    logic [11:0] r_tile_mm;
    logic [2:0]  r_margin_tiles;

    logi_pkg::t_cmd    w_cmd;
    logi_pkg::t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_offset <= 15'd0;
            r_tile_mm <= 12'd100;
            r_margin_tiles <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                logi_pkg::REG_HEADING: r_heading_offset <= i_cfg_data;
                logi_pkg::REG_TILE: r_tile_mm <= i_cfg_data[11:0];
                logi_pkg::REG_MARGIN: r_margin_tiles <= i_cfg_data[2:0];
                default: r_margin_tiles <= r_margin_tiles;
            endcase
        end
    end

    // The controller steps through the phases; the datapath does the work.
    logi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    logi_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_heading_offset (r_heading_offset),
        .i_tile_mm        (r_tile_mm),
        .i_margin_tiles   (r_margin_tiles),
        .i_req_type       (i_req_type),
        .i_range_mm       (i_range_mm),
        .i_bearing        (i_bearing),
        .i_quality        (i_quality),
        .i_end_of_scan    (i_end_of_scan),
        .i_read_x         (i_read_x),
        .i_read_y         (i_read_y),
        .o_hit_x          (o_hit_x),
        .o_hit_y          (o_hit_y),
        .o_hit_in_map     (o_hit_in_map),
        .o_sample_skipped (o_sample_skipped),
        .o_raw_cell       (o_raw_cell),
        .o_safe_cell      (o_safe_cell),
        .o_read_ok        (o_read_ok),
        .o_scan_done      (o_scan_done)
    );

endmodule
`default_nettype wire

[hw/rtl/logi_ctrl.sv]
// Sequencing state machine of the occupancy grid block.
`default_nettype none
module logi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logi_pkg::t_status i_status,
    output logi_pkg::t_cmd        o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);

    logi_pkg::t_state r_state;
    logi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= logi_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            logi_pkg::ST_CLEAR: if (i_status.clr_last) n_state = logi_pkg::ST_IDLE;
            logi_pkg::ST_IDLE: if (i_start) n_state = logi_pkg::ST_DISPATCH;
            logi_pkg::ST_DISPATCH: begin
                if (i_status.req) n_state = logi_pkg::ST_RD;
                else if (i_status.skip) n_state = logi_pkg::ST_OUT;
                else n_state = logi_pkg::ST_ANG1;
            end
            logi_pkg::ST_ANG1: n_state = logi_pkg::ST_ANG2;
            logi_pkg::ST_ANG2: n_state = logi_pkg::ST_ANG3;
            logi_pkg::ST_ANG3: n_state = logi_pkg::ST_CORDIC;
            logi_pkg::ST_CORDIC: if (i_status.cordic_last) n_state = logi_pkg::ST_ROUND;
            logi_pkg::ST_ROUND: n_state = logi_pkg::ST_MUL;
            logi_pkg::ST_MUL: n_state = logi_pkg::ST_DIVINIT;
            logi_pkg::ST_DIVINIT: n_state = logi_pkg::ST_DIV;
            logi_pkg::ST_DIV: if (i_status.div_last) n_state = logi_pkg::ST_FIX;
            logi_pkg::ST_FIX: n_state = logi_pkg::ST_BOUND;
            logi_pkg::ST_BOUND: begin
                if (i_status.in_map) n_state = logi_pkg::ST_RAWWR;
                else n_state = logi_pkg::ST_OUT;
            end
            logi_pkg::ST_RAWWR: n_state = logi_pkg::ST_DISC;
            logi_pkg::ST_DISC: if (i_status.disc_last) n_state = logi_pkg::ST_OUT;
            logi_pkg::ST_RD: n_state = logi_pkg::ST_RD2;
            logi_pkg::ST_RD2: n_state = logi_pkg::ST_OUT;
            logi_pkg::ST_OUT: n_state = logi_pkg::ST_IDLE;
            default: n_state = logi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            logi_pkg::ST_CLEAR: o_cmd.clr = 1'b1;
            logi_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            logi_pkg::ST_ANG1: o_cmd.ang1 = 1'b1;
            logi_pkg::ST_ANG2: o_cmd.ang2 = 1'b1;
            logi_pkg::ST_ANG3: o_cmd.ang3 = 1'b1;
            logi_pkg::ST_CORDIC: o_cmd.cordic = 1'b1;
            logi_pkg::ST_ROUND: o_cmd.round = 1'b1;
            logi_pkg::ST_MUL: o_cmd.mul = 1'b1;
            logi_pkg::ST_DIVINIT: o_cmd.divinit = 1'b1;
            logi_pkg::ST_DIV: o_cmd.div = 1'b1;
            logi_pkg::ST_FIX: o_cmd.fix = 1'b1;
            logi_pkg::ST_BOUND: o_cmd.bound = 1'b1;
            logi_pkg::ST_RAWWR: o_cmd.rawwr = 1'b1;
            logi_pkg::ST_DISC: o_cmd.disc = 1'b1;
            logi_pkg::ST_RD: o_cmd.rd = 1'b1;
            logi_pkg::ST_RD2: o_cmd.rd2 = 1'b1;
            logi_pkg::ST_OUT: o_valid = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/logi_dp.sv]
// Datapath of the occupancy grid block: angle, CORDIC, divider, disc walk and maps.
`default_nettype none
module logi_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logi_pkg::t_cmd         i_cmd,
    output logi_pkg::t_status           o_status,
    input  wire logic [14:0]            i_heading_offset,
    input  wire logic [11:0]            i_tile_mm,
    input  wire logic [2:0]             i_margin_tiles,
    input  wire logic                   i_req_type,
    input  wire logic [15:0]            i_range_mm,
    input  wire logic [14:0]            i_bearing,
    input  wire logic [7:0]             i_quality,
    input  wire logic                   i_end_of_scan,
    input  wire logic signed [5:0]      i_read_x,
    input  wire logic signed [5:0]      i_read_y,
    output logic signed [16:0]          o_hit_x,
    output logic signed [16:0]          o_hit_y,
    output logic                        o_hit_in_map,
    output logic                        o_sample_skipped,
    output logic [2:0]                  o_raw_cell,
    output logic [2:0]                  o_safe_cell,
    output logic                        o_read_ok,
    output logic                        o_scan_done
);

    localparam int AW = logi_pkg::ADDR_W;
    localparam int MW = logi_pkg::M_W;
    localparam int DW = logi_pkg::D_W;
    localparam int SW = logi_pkg::SQ_W;

    // Captured transaction
    logic                r_req;
    logic [15:0]         r_range;
    logic [14:0]         r_bear;
    logic signed [5:0]   r_rx;
    logic signed [5:0]   r_ry;

    // Angle and CORDIC
    logic [14:0]         r_bm, r_hm, r_ang;
    logic [1:0]          r_quad;
    logic signed [33:0]  r_cx, r_cy;
    logic signed [31:0]  r_cz;
    logic [4:0]          r_i;
    logic signed [21:0]  r_s, r_c;

    // Division
    logic signed [18:0]  r_tx, r_ty;
    logic [15:0]         r_qx, r_qy;
    logic [11:0]         r_remx, r_remy;
    logic                r_negx, r_negy;
    logic [11:0]         r_div;
    logic [3:0]          r_k;

    // Disc walk
    logic [MW-1:0]       r_m;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [AW-1:0]       r_clr;

    // Maps
    logic [2:0]          r_raw_mem [logi_pkg::CELLS];
    logic [2:0]          r_safe_mem [logi_pkg::CELLS];
    logic [2:0]          r_raw_q, r_safe_q;

    logic signed [17:0]  w_hx, w_hy, w_px, w_py, w_rdx, w_rdy;
    logic                w_disc_hit;
    logic                w_raw_we, w_safe_we;
    logic [AW-1:0]       w_raw_wa, w_safe_wa, w_rd_addr;
    logic [2:0]          w_raw_wd, w_safe_wd;
    logic signed [SW-1:0] w_sq;
    logic signed [SW-1:0] w_mm;
    logic [12:0]         w_trx, w_try;
    logic signed [38:0]  w_pmx, w_pmy;
    logic signed [23:0]  w_rs, w_rc;
    logic [16:0]         w_qx1, w_qy1;
    logic [2:0]          w_mclip;

    assign w_hx = 18'(o_hit_x);
    assign w_hy = 18'(o_hit_y);
    assign w_px = w_hx + 18'(r_dx);
    assign w_py = w_hy + 18'(r_dy);
    assign w_rdx = 18'(r_rx);
    assign w_rdy = 18'(r_ry);

    assign w_sq = SW'(r_dx) * SW'(r_dx) + SW'(r_dy) * SW'(r_dy);
    assign w_mm = SW'($signed({1'b0, r_m})) * SW'($signed({1'b0, r_m}));
    assign w_disc_hit = (w_sq <= w_mm) && logi_pkg::cell_in_map(w_px, w_py);

    assign w_mclip = (32'(i_margin_tiles) > logi_pkg::MAX_MARGIN)
                     ? 3'(logi_pkg::MAX_MARGIN) : i_margin_tiles;

    assign o_status.clr_last = (32'(r_clr) == logi_pkg::CELLS - 1);
    assign o_status.req = r_req;
    assign o_status.skip = o_sample_skipped;
    assign o_status.cordic_last = (32'(r_i) == logi_pkg::CORDIC_STEPS - 1);
    assign o_status.div_last = (r_k == 4'd15);
    assign o_status.in_map = logi_pkg::cell_in_map(w_hx, w_hy);
    assign o_status.disc_last = (r_dx == DW'($signed({1'b0, r_m}))) &&
                                (r_dy == DW'($signed({1'b0, r_m})));

    // Restoring division trial steps, one quotient bit per cycle in each lane.
    assign w_trx = {r_remx, r_qx[15]};
    assign w_try = {r_remy, r_qy[15]};

    assign w_pmx = -($signed({1'b0, r_range}) * 39'(r_s));
    assign w_pmy = $signed({1'b0, r_range}) * 39'(r_c);

    // Rounding to Q20 works on the full CORDIC width before narrowing.
    assign w_rs = 24'((r_cy + 34'sd512) >>> 10);
    assign w_rc = 24'((r_cx + 34'sd512) >>> 10);

    assign w_qx1 = 17'(r_qx) + 17'(r_remx != 12'd0);
    assign w_qy1 = 17'(r_qy) + 17'(r_remy != 12'd0);

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_i <= '0;
            r_k <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.ang3) r_i <= '0;
            else if (i_cmd.cordic) r_i <= r_i + 5'd1;
            if (i_cmd.divinit) r_k <= '0;
            else if (i_cmd.div) r_k <= r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_range <= i_range_mm;
            r_bear <= i_bearing;
            r_rx <= i_read_x;
            r_ry <= i_read_y;
            o_hit_x <= '0;
            o_hit_y <= '0;
            o_hit_in_map <= 1'b0;
            o_sample_skipped <= !i_req_type && (i_range_mm == 16'd0) && (i_quality == 8'd0);
            o_raw_cell <= logi_pkg::CELL_FREE;
            o_safe_cell <= logi_pkg::CELL_FREE;
            o_read_ok <= 1'b0;
            o_scan_done <= !i_req_type && i_end_of_scan;
        end
        if (i_cmd.ang1) begin
            r_bm <= (r_bear >= 15'(logi_pkg::TURN)) ? r_bear - 15'(logi_pkg::TURN) : r_bear;
            r_hm <= (i_heading_offset >= 15'(logi_pkg::TURN))
                    ? i_heading_offset - 15'(logi_pkg::TURN) : i_heading_offset;
        end
        if (i_cmd.ang2) begin
            r_ang <= (r_bm >= r_hm) ? r_bm - r_hm : r_bm + 15'(logi_pkg::TURN) - r_hm;
        end
        if (i_cmd.ang3) begin
            r_cx <= 34'(logi_pkg::CORDIC_GAIN);
            r_cy <= '0;
            if (r_ang >= 15'(3 * logi_pkg::QUARTER)) begin
                r_quad <= 2'd3;
                r_cz <= $signed({3'b000, 13'(r_ang - 15'(3 * logi_pkg::QUARTER)), 16'd0});
            end else if (r_ang >= 15'(2 * logi_pkg::QUARTER)) begin
                r_quad <= 2'd2;
                r_cz <= $signed({3'b000, 13'(r_ang - 15'(2 * logi_pkg::QUARTER)), 16'd0});
            end else if (r_ang >= 15'(logi_pkg::QUARTER)) begin
                r_quad <= 2'd1;
                r_cz <= $signed({3'b000, 13'(r_ang - 15'(logi_pkg::QUARTER)), 16'd0});
            end else begin
                r_quad <= 2'd0;
                r_cz <= $signed({3'b000, r_ang[12:0], 16'd0});
            end
        end
        if (i_cmd.cordic) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - (r_cy >>> r_i);
                r_cy <= r_cy + (r_cx >>> r_i);
                r_cz <= r_cz - logi_pkg::atan_val(r_i);
            end else begin
                r_cx <= r_cx + (r_cy >>> r_i);
                r_cy <= r_cy - (r_cx >>> r_i);
                r_cz <= r_cz + logi_pkg::atan_val(r_i);
            end
        end
        if (i_cmd.round) begin
            case (r_quad)
                2'd0: begin r_s <= 22'(w_rs); r_c <= 22'(w_rc); end
                2'd1: begin r_s <= 22'(w_rc); r_c <= -22'(w_rs); end
                2'd2: begin r_s <= -22'(w_rs); r_c <= -22'(w_rc); end
                default: begin r_s <= -22'(w_rc); r_c <= 22'(w_rs); end
            endcase
        end
        if (i_cmd.mul) begin
            r_tx <= 19'(w_pmx >>> 20);
            r_ty <= 19'(w_pmy >>> 20);
        end
        if (i_cmd.divinit) begin
            r_negx <= r_tx[18];
            r_negy <= r_ty[18];
            r_qx <= r_tx[18] ? 16'(-r_tx) : r_tx[15:0];
            r_qy <= r_ty[18] ? 16'(-r_ty) : r_ty[15:0];
            r_remx <= '0;
            r_remy <= '0;
            r_div <= (i_tile_mm == 12'd0) ? 12'd1 : i_tile_mm;
        end
        if (i_cmd.div) begin
            if (w_trx >= {1'b0, r_div}) begin
                r_remx <= 12'(w_trx - {1'b0, r_div});
                r_qx <= {r_qx[14:0], 1'b1};
            end else begin
                r_remx <= w_trx[11:0];
                r_qx <= {r_qx[14:0], 1'b0};
            end
            if (w_try >= {1'b0, r_div}) begin
                r_remy <= 12'(w_try - {1'b0, r_div});
                r_qy <= {r_qy[14:0], 1'b1};
            end else begin
                r_remy <= w_try[11:0];
                r_qy <= {r_qy[14:0], 1'b0};
            end
        end
        if (i_cmd.fix) begin
            o_hit_x <= r_negx ? -$signed(w_qx1) : $signed({1'b0, r_qx});
            o_hit_y <= r_negy ? -$signed(w_qy1) : $signed({1'b0, r_qy});
        end
        if (i_cmd.bound) begin
            o_hit_in_map <= logi_pkg::cell_in_map(w_hx, w_hy);
            r_m <= MW'(w_mclip);
            r_dx <= -DW'($signed({1'b0, w_mclip}));
            r_dy <= -DW'($signed({1'b0, w_mclip}));
        end
        if (i_cmd.disc) begin
            if (r_dx == DW'($signed({1'b0, r_m}))) begin
                r_dx <= -DW'($signed({1'b0, r_m}));
                r_dy <= r_dy + DW'(1);
            end else begin
                r_dx <= r_dx + DW'(1);
            end
        end
        if (i_cmd.rd2) begin
            o_read_ok <= logi_pkg::cell_in_map(w_rdx, w_rdy);
            o_raw_cell <= logi_pkg::cell_in_map(w_rdx, w_rdy) ? r_raw_q : logi_pkg::CELL_FREE;
            o_safe_cell <= logi_pkg::cell_in_map(w_rdx, w_rdy) ? r_safe_q : logi_pkg::CELL_FREE;
        end
    end

    // Map port selection: the clearing pass, the hit cell, the disc and reads.
    always_comb begin
        w_rd_addr = logi_pkg::cell_addr(w_rdx, w_rdy);
        w_raw_we = i_cmd.clr || i_cmd.rawwr;
        w_safe_we = i_cmd.clr || (i_cmd.disc && w_disc_hit);
        if (i_cmd.clr) begin
            w_raw_wa = r_clr;
            w_safe_wa = r_clr;
            w_raw_wd = (32'(r_clr) == logi_pkg::CENTRE_ADDR) ? logi_pkg::CELL_LOC
                                                              : logi_pkg::CELL_FREE;
            w_safe_wd = w_raw_wd;
        end else begin
            w_raw_wa = logi_pkg::cell_addr(w_hx, w_hy);
            w_safe_wa = logi_pkg::cell_addr(w_px, w_py);
            w_raw_wd = logi_pkg::CELL_OBST;
            w_safe_wd = logi_pkg::CELL_OBST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_raw_we) r_raw_mem[w_raw_wa] <= w_raw_wd;
        r_raw_q <= r_raw_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_safe_we) r_safe_mem[w_safe_wa] <= w_safe_wd;
        r_safe_q <= r_safe_mem[w_rd_addr];
    end

endmodule
`default_nettype wire

[tb/tb_lidar_occupancy_grid_inflate.sv]
// Self-checking testbench for the lidar occupancy grid with obstacle inflation.
`timescale 1ns / 100ps
`default_nettype none
module tb_lidar_occupancy_grid_inflate;

    // One request as offered to the block.
    typedef struct {
        bit              is_read;
        bit [15:0]       range_mm;
        bit [14:0]       bearing;
        bit [7:0]        quality;
        bit              eos;
        bit signed [5:0] rx;
        bit signed [5:0] ry;
    } t_lidar_req;

    // One result as the block should report it.
    typedef struct packed {
        logic [16:0] hit_x;
        logic [16:0] hit_y;
        logic        in_map;
        logic        skipped;
        logic [2:0]  raw_cell;
        logic [2:0]  safe_cell;
        logic        read_ok;
        logic        scan_done;
    } t_grid_result;

    localparam int HALF_COLS = logi_pkg::GRID_COLS / 2;
    localparam int HALF_ROWS = logi_pkg::GRID_ROWS / 2;
    localparam int DRAIN_CYCLES = 320;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic i_req_type = 1'b0;
    logic [15:0] i_range_mm = '0;
    logic [14:0] i_bearing = '0;
    logic [7:0] i_quality = '0;
    logic i_end_of_scan = 1'b0;
    logic signed [5:0] i_read_x = '0;
    logic signed [5:0] i_read_y = '0;
    logic i_cfg_we = 1'b0;
    logic [logi_pkg::CFG_IDX_W-1:0] i_cfg_idx = logi_pkg::REG_HEADING;
    logic [logi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_busy;
    logic o_valid;
    logic signed [16:0] o_hit_x;
    logic signed [16:0] o_hit_y;
    logic o_hit_in_map;
    logic o_sample_skipped;
    logic [2:0] o_raw_cell;
    logic [2:0] o_safe_cell;
    logic o_read_ok;
    logic o_scan_done;

    lidar_occupancy_grid_inflate u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_range_mm(i_range_mm), .i_bearing(i_bearing),
        .i_quality(i_quality), .i_end_of_scan(i_end_of_scan),
        .i_read_x(i_read_x), .i_read_y(i_read_y),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_hit_x(o_hit_x), .o_hit_y(o_hit_y),
        .o_hit_in_map(o_hit_in_map), .o_sample_skipped(o_sample_skipped),
        .o_raw_cell(o_raw_cell), .o_safe_cell(o_safe_cell),
        .o_read_ok(o_read_ok), .o_scan_done(o_scan_done)
    );

    // The clock runs at 125 MHz.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and results the block still owes us.
    t_lidar_req   pending_reqs[$];
    t_grid_result owed_results[$];

    // The testbench's own view of the configuration and of both maps.
    int unsigned heading_cfg = 0;
    int unsigned tile_cfg = 100;
    int unsigned margin_cfg = 2;
    logic [2:0] raw_grid[logi_pkg::CELLS];
    logic [2:0] safe_grid[logi_pkg::CELLS];

    int sender_idle_pct = 23;
    int errors = 0;
    int n_samples = 0;
    int n_reads = 0;
    int n_hits = 0;
    int n_results = 0;

    // Arithmetic shifts on signed longint already floor, as the datapath does.
    function automatic void cordic_sin_cos(input int unsigned ang,
                                           output longint s, output longint c);
        longint x, y, z, xs, ys;
        int unsigned quad;
        x = logi_pkg::CORDIC_GAIN;
        y = 0;
        z = longint'(ang % logi_pkg::QUARTER) * 65536;
        quad = ang / logi_pkg::QUARTER;
        for (int i = 0; i < logi_pkg::CORDIC_STEPS; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x -= xs; y += ys; z -= logi_pkg::atan_val(i[4:0]);
            end else begin
                x += xs; y -= ys; z += logi_pkg::atan_val(i[4:0]);
            end
        end
        x = (x + 512) >>> 10;
        y = (y + 512) >>> 10;
        case (quad & 3)
            0: begin s = y;  c = x;  end
            1: begin s = x;  c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function automatic longint floored_quotient(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic bit on_grid(input longint x, input longint y);
        return x >= -HALF_COLS && x < logi_pkg::GRID_COLS - HALF_COLS &&
               y >= -HALF_ROWS && y < logi_pkg::GRID_ROWS - HALF_ROWS;
    endfunction

    function automatic int grid_index(input longint x, input longint y);
        return int'((y + HALF_ROWS) * logi_pkg::GRID_COLS + (x + HALF_COLS));
    endfunction

    // Works out the result of one accepted request and updates both maps.
    function automatic t_grid_result map_request(input t_lidar_req r);
        t_grid_result res;
        int unsigned ang;
        longint s, c, den, hx, hy, m;
        res = '0;
        hx = 0;
        hy = 0;
        if (!r.is_read) begin
            res.scan_done = r.eos;
            if (r.range_mm == 0 && r.quality == 0) begin
                res.skipped = 1'b1;
            end else begin
                ang = (r.bearing % logi_pkg::TURN + logi_pkg::TURN
                       - heading_cfg % logi_pkg::TURN) % logi_pkg::TURN;
                cordic_sin_cos(ang, s, c);
                den = longint'(tile_cfg == 0 ? 1 : tile_cfg) << 20;
                hx = floored_quotient(-longint'(r.range_mm) * s, den);
                hy = floored_quotient(longint'(r.range_mm) * c, den);
                if (on_grid(hx, hy)) begin
                    m = margin_cfg > logi_pkg::MAX_MARGIN ? logi_pkg::MAX_MARGIN : margin_cfg;
                    res.in_map = 1'b1;
                    raw_grid[grid_index(hx, hy)] = logi_pkg::CELL_OBST;
                    for (longint dy = -m; dy <= m; dy++)
                        for (longint dx = -m; dx <= m; dx++)
                            if (dx * dx + dy * dy <= m * m && on_grid(hx + dx, hy + dy))
                                safe_grid[grid_index(hx + dx, hy + dy)] = logi_pkg::CELL_OBST;
                end
            end
            res.hit_x = hx[16:0];
            res.hit_y = hy[16:0];
        end else if (on_grid(r.rx, r.ry)) begin
            res.read_ok = 1'b1;
            res.raw_cell = raw_grid[grid_index(r.rx, r.ry)];
            res.safe_cell = safe_grid[grid_index(r.rx, r.ry)];
        end
        return res;
    endfunction

    // Driver: offers queued requests, holding each until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                owed_results.push_back(map_request('{i_req_type, i_range_mm, i_bearing,
                    i_quality, i_end_of_scan, i_read_x, i_read_y}));
                if (i_req_type) n_reads++;
                else n_samples++;
            end
            if (!i_start || !o_busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    t_lidar_req nx;
                    nx = pending_reqs.pop_front();
                    i_start <= 1'b1;
                    i_req_type <= nx.is_read;
                    i_range_mm <= nx.range_mm;
                    i_bearing <= nx.bearing;
                    i_quality <= nx.quality;
                    i_end_of_scan <= nx.eos;
                    i_read_x <= nx.rx;
                    i_read_y <= nx.ry;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest one owed.
    // It also runs the watchdog, which counts cycles with no request taken and no result strobed.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        t_grid_result got, want;
        if ((i_start && !o_busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            got = '{o_hit_x, o_hit_y, o_hit_in_map, o_sample_skipped, o_raw_cell,
                    o_safe_cell, o_read_ok, o_scan_done};
            n_results++;
            if (got.in_map) n_hits++;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result %p", got);
            end else begin
                want = owed_results.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic t_lidar_req sample_req(input int rng, input int brg, input int q,
                                              input bit eos);
        return '{1'b0, rng[15:0], brg[14:0], q[7:0], eos, 6'sd0, 6'sd0};
    endfunction

    function automatic t_lidar_req read_req(input int x, input int y);
        return '{1'b1, 16'd0, 15'd0, 8'd0, 1'b0, x[5:0], y[5:0]};
    endfunction

    // Mostly samples that land on the grid, plus reads and a little noise.
    function automatic t_lidar_req random_req();
        t_lidar_req r;
        int unsigned pick, reach;
        pick = $urandom_range(0, 99);
        reach = (tile_cfg == 0 ? 1 : tile_cfg) * 40;
        if (reach > 65535) reach = 65535;
        r = sample_req($urandom_range(0, reach), $urandom_range(0, logi_pkg::TURN - 1),
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        if (pick < 35) begin
            r = read_req($urandom_range(0, 63), $urandom_range(0, 63));
            r.range_mm = 16'($urandom);
            r.bearing = 15'($urandom);
            r.quality = 8'($urandom);
            r.eos = 1'($urandom);
        end else if (pick < 40) begin
            r.range_mm = '0;
            r.quality = '0;
        end else if (pick < 50) begin
            r.range_mm = 16'($urandom);
        end
        if (!r.is_read) begin
            r.rx = 6'($urandom);
            r.ry = 6'($urandom);
        end
        return r;
    endfunction

    task automatic write_reg(input logic [logi_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[logi_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            logi_pkg::REG_HEADING: heading_cfg = val & 16'h7FFF;
            logi_pkg::REG_TILE: tile_cfg = val & 12'hFFF;
            default: margin_cfg = val & 3'h7;
        endcase
    endtask

    // Waits for the queue and the block to empty, then lets the disc walk settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_start || owed_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input int unsigned hdg,
                                input int unsigned tile, input int unsigned margin);
        write_reg(logi_pkg::REG_HEADING, hdg);
        write_reg(logi_pkg::REG_TILE, tile);
        write_reg(logi_pkg::REG_MARGIN, margin);
        repeat (count) pending_reqs.push_back(random_req());
        drain();
    endtask

    initial begin
        for (int i = 0; i < logi_pkg::CELLS; i++) begin
            raw_grid[i] = logi_pkg::CELL_FREE;
            safe_grid[i] = logi_pkg::CELL_FREE;
        end
        raw_grid[logi_pkg::CENTRE_ADDR] = logi_pkg::CELL_LOC;
        safe_grid[logi_pkg::CENTRE_ADDR] = logi_pkg::CELL_LOC;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration: the four quadrant
        // boundaries and the top of the bearing range, a skipped sample, a
        // zero range with some quality, the longest range, hits on either edge
        // of the map, a hit over the robot's own cell and reads of the corners.
        pending_reqs.push_back(read_req(0, 0));
        pending_reqs.push_back(sample_req(500, 0, 100, 0));
        pending_reqs.push_back(sample_req(500, logi_pkg::QUARTER, 255, 0));
        pending_reqs.push_back(sample_req(500, 2 * logi_pkg::QUARTER, 1, 0));
        pending_reqs.push_back(sample_req(500, 3 * logi_pkg::QUARTER, 100, 0));
        pending_reqs.push_back(sample_req(500, logi_pkg::TURN - 1, 100, 1));
        pending_reqs.push_back(sample_req(0, 1234, 0, 1));
        pending_reqs.push_back(sample_req(0, 0, 7, 0));
        pending_reqs.push_back(sample_req(65535, 32767, 255, 0));
        pending_reqs.push_back(sample_req(3150, 0, 50, 0));
        pending_reqs.push_back(sample_req(3250, 0, 50, 0));
        pending_reqs.push_back(sample_req(3200, 2 * logi_pkg::QUARTER, 50, 0));
        pending_reqs.push_back(sample_req(3200, logi_pkg::QUARTER, 50, 0));
        pending_reqs.push_back(sample_req(3300, 3 * logi_pkg::QUARTER, 50, 0));
        pending_reqs.push_back(sample_req(50, 0, 9, 0));
        pending_reqs.push_back(read_req(0, 0));
        pending_reqs.push_back(read_req(-32, -32));
        pending_reqs.push_back(read_req(31, 31));
        pending_reqs.push_back(read_req(0, 31));
        pending_reqs.push_back(read_req(2, 5));
        pending_reqs.push_back(read_req(-31, 0));
        drain();

        // Random phases walk the registers through their extremes, including
        // a zero tile size, which the block must treat as one millimetre.
        random_phase(260, 0, 100, 2);
        random_phase(260, logi_pkg::TURN - 1, 1, 7);
        sender_idle_pct = 68;
        random_phase(260, $urandom_range(0, logi_pkg::TURN - 1), 4095, 0);
        random_phase(260, 16384, 0, 1);
        sender_idle_pct = 0;
        random_phase(260, $urandom_range(0, logi_pkg::TURN - 1), $urandom_range(20, 300), 7);
        random_phase(260, 32767, 100, $urandom_range(0, 7));

        $display("Covered %0d samples (%0d on the grid) and %0d cell reads, %0d results",
                 n_samples, n_hits, n_reads, n_results);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hw/rtl/logi_pkg.sv
hw/rtl/logi_ctrl.sv
hw/rtl/logi_dp.sv
hw/rtl/lidar_occupancy_grid_inflate.sv
tb/tb_lidar_occupancy_grid_inflate.sv
